FILE: rtl/smdm_pkg.sv
// smdm_pkg: shared codes and types for the signed multiply / divide / remainder unit
// used by the channel interfaces, the controller, the datapath and the top level
`default_nettype none

package smdm_pkg;

  // default operand width
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // operation select field
  localparam int unsigned FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_MUL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DIV = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REM = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture operands, clear accumulator
    logic step;    // one multiply or divide iteration
    logic finish;  // sign fixup into the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;    // iteration counter has reached its final step
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/smdm_req_if.sv
// smdm_req_if: request channel carrying one operation word (func, a, b)
// depends on smdm_pkg for the func field width
`default_nettype none

interface smdm_req_if #(
  parameter int unsigned DATA_WIDTH = smdm_pkg::DATA_WIDTH_DEF
);
  import smdm_pkg::*;

  logic                         valid;
  logic                         ready;
  logic        [FUNC_W-1:0]     func;
  logic signed [DATA_WIDTH-1:0] a;
  logic signed [DATA_WIDTH-1:0] b;

  modport source (output valid, output func, output a, output b, input ready);
  modport sink   (input valid, input func, input a, input b, output ready);

endinterface

`default_nettype wire

FILE: rtl/smdm_rsp_if.sv
// smdm_rsp_if: response channel carrying one result word
// depends on smdm_pkg for the default width
`default_nettype none

interface smdm_rsp_if #(
  parameter int unsigned DATA_WIDTH = smdm_pkg::DATA_WIDTH_DEF
);

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);

endinterface

`default_nettype wire

FILE: rtl/smdm_ctrl.sv
// smdm_ctrl: sequencing state machine and output valid flag
// depends on smdm_pkg for the command and status structs
`default_nettype none

module smdm_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  input  smdm_pkg::status_t status_i,
  output smdm_pkg::cmd_t    cmd_o
);
  import smdm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_finish;

  // output register is free when empty or being drained this cycle
  assign can_finish = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.step = 1'b1;
        if (status_i.last) state_d = S_DONE;
      end
      S_DONE: begin
        if (can_finish) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid: set on finish, cleared when the word is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/smdm_dp.sv
// smdm_dp: operand registers, shift-add multiply / restoring divide step,
// iteration counter, sign fixup and output register; depends on smdm_pkg
`default_nettype none

module smdm_dp #(
  parameter int unsigned DATA_WIDTH = smdm_pkg::DATA_WIDTH_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  smdm_pkg::cmd_t                  cmd_i,
  output smdm_pkg::status_t               status_o,
  input  wire [smdm_pkg::FUNC_W-1:0]      func_i,
  input  wire [DATA_WIDTH-1:0]            a_i,
  input  wire [DATA_WIDTH-1:0]            b_i,
  output logic [DATA_WIDTH-1:0]           result_o
);
  import smdm_pkg::*;

  localparam int unsigned CntW = $clog2(DATA_WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(DATA_WIDTH - 1);

  logic [FUNC_W-1:0]     func_q;
  logic                  neg_q;     // sign of product / quotient
  logic                  nega_q;    // sign of remainder follows dividend
  logic                  bzero_q;
  logic [DATA_WIDTH:0]   acc_q, acc_d;      // product or partial remainder
  logic [DATA_WIDTH-1:0] opa_q, opa_d;      // multiplicand or dividend / quotient
  logic [DATA_WIDTH-1:0] opb_q, opb_d;      // multiplier or divisor
  logic [CntW-1:0]       cnt_q;
  logic [DATA_WIDTH-1:0] result_q, result_d;

  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic [DATA_WIDTH:0]   rem_sh, rem_diff;
  logic                  rem_ge;
  logic [DATA_WIDTH-1:0] fix_val, fix_neg;
  logic                  fix_sign;

  // operand magnitudes
  assign mag_a = a_i[DATA_WIDTH-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[DATA_WIDTH-1] ? (~b_i + 1'b1) : b_i;

  // restoring divide trial subtract
  assign rem_sh   = {acc_q[DATA_WIDTH-1:0], opa_q[DATA_WIDTH-1]};
  assign rem_ge   = (rem_sh >= {1'b0, opb_q});
  assign rem_diff = rem_sh - {1'b0, opb_q};

  // one iteration of the selected algorithm
  always_comb begin
    acc_d = acc_q;
    opa_d = opa_q;
    opb_d = opb_q;
    if (func_q == FUNC_MUL) begin
      acc_d = {1'b0, acc_q[DATA_WIDTH-1:0] + (opb_q[0] ? opa_q : '0)};
      opa_d = {opa_q[DATA_WIDTH-2:0], 1'b0};
      opb_d = {1'b0, opb_q[DATA_WIDTH-1:1]};
    end else begin
      acc_d = rem_ge ? rem_diff : rem_sh;
      opa_d = {opa_q[DATA_WIDTH-2:0], rem_ge};
    end
  end

  // sign fixup shared by all operations
  always_comb begin
    fix_val  = acc_q[DATA_WIDTH-1:0];
    fix_sign = neg_q;
    result_d = '0;
    case (func_q)
      FUNC_MUL: begin
        fix_val  = acc_q[DATA_WIDTH-1:0];
        fix_sign = neg_q;
      end
      FUNC_DIV: begin
        fix_val  = opa_q;
        fix_sign = neg_q;
      end
      FUNC_REM: begin
        fix_val  = acc_q[DATA_WIDTH-1:0];
        fix_sign = nega_q;
      end
      default: begin
        fix_val  = '0;
        fix_sign = 1'b0;
      end
    endcase
    fix_neg = fix_sign ? (~fix_val + 1'b1) : fix_val;
    case (func_q)
      FUNC_MUL: result_d = fix_neg;
      FUNC_DIV: result_d = bzero_q ? '0 : fix_neg;
      FUNC_REM: result_d = bzero_q ? '0 : fix_neg;
      default:  result_d = '0;
    endcase
  end

  // iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= CntLast;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // operand and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      neg_q   <= a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
      nega_q  <= a_i[DATA_WIDTH-1];
      bzero_q <= (b_i == '0);
      acc_q   <= '0;
      opa_q   <= mag_a;
      opb_q   <= mag_b;
    end else if (cmd_i.step) begin
      acc_q <= acc_d;
      opa_q <= opa_d;
      opb_q <= opb_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) result_q <= result_d;
  end

  assign status_o.last = (cnt_q == '0);
  assign result_o      = result_q;

endmodule

`default_nettype wire

FILE: rtl/signed_mul_div_mod_unit.sv
// signed_mul_div_mod_unit: signed multiply, divide and remainder, one bit per cycle
// depends on smdm_pkg, smdm_req_if, smdm_rsp_if, smdm_ctrl and smdm_dp
//
//   channel  dir  fields            handshake
//   req_i    in   func, a, b        valid / ready
//   rsp_o    out  result            valid / ready
//
// the accepting edge loads the operands; DATA_WIDTH iterations of the shared
// shift/add-subtract step follow, then a sign fixup into the output register;
// a new word is accepted only after the previous one has been through the fixup.
// req_i.ready is high only while no item is in flight; a new word may be accepted
// while the previous result still waits in the output register, and the fixup
// cycle stalls until that register is free. reset clears control state only.
`default_nettype none

module signed_mul_div_mod_unit #(
  parameter int unsigned DATA_WIDTH = smdm_pkg::DATA_WIDTH_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  smdm_req_if.sink   req_i,
  smdm_rsp_if.source rsp_o
);
  import smdm_pkg::*;

  cmd_t    cmd;
  status_t status;

  smdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  smdm_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .func_i   (req_i.func),
    .a_i      (req_i.a),
    .b_i      (req_i.b),
    .result_o (rsp_o.result)
  );

  // only one item in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while an item is in flight");

  // commands are mutually exclusive
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.step, cmd.finish}))
    else $error("more than one datapath command at once");

  // a new result appears only after a finish command
  a_valid_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.finish))
    else $error("result valid without a finish command");

  // finish never overwrites a result that is not being taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!rsp_o.valid || rsp_o.ready))
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench: random and directed check of signed_mul_div_mod_unit (multiply, divide, remainder)
// depends on smdm_pkg, smdm_req_if, smdm_rsp_if and the unit's rtl
`timescale 1ns / 1ps

module testbench;
  import smdm_pkg::*;

  localparam int unsigned DW = DATA_WIDTH_DEF;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic signed [DW-1:0] INT_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] INT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam int unsigned RANDOM_WORDS = 1250;
  localparam int unsigned UNIT_LATENCY = DW + 2;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned REPORT_LIMIT = 200;

  // expected results of the unit, oldest first
  class mul_div_scoreboard;
    logic signed [DW-1:0] pending_results[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // signed multiply low word, truncated divide, remainder; zero divisor gives 0
    function logic signed [DW-1:0] signed_op_result(logic [FUNC_W-1:0] func,
                                                    logic signed [DW-1:0] a,
                                                    logic signed [DW-1:0] b);
      longint dividend;
      longint divisor;
      longint quotient;
      longint wide;
      dividend = a;
      divisor  = b;
      wide     = 0;
      case (func)
        FUNC_MUL: begin
          wide = dividend * divisor;
        end
        FUNC_DIV: begin
          if (divisor != 0) wide = dividend / divisor;
        end
        FUNC_REM: begin
          if (divisor != 0) begin
            quotient = dividend / divisor;
            wide = dividend - quotient * divisor;
          end
        end
        default: begin
          wide = 0;
        end
      endcase
      return wide[DW-1:0];
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic signed [DW-1:0] a,
                               logic signed [DW-1:0] b);
      pending_results.push_back(signed_op_result(func, a, b));
    endfunction

    function void check_result(logic signed [DW-1:0] got);
      logic signed [DW-1:0] want;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $error("result with nothing pending: actual %0d", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $error("result mismatch: expected %0d, actual %0d", want, got);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int unsigned idle_cycles = 0;
  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;

  smdm_req_if #(.DATA_WIDTH(DW)) req_if ();
  smdm_rsp_if #(.DATA_WIDTH(DW)) rsp_if ();

  mul_div_scoreboard sb = new();

  signed_mul_div_mod_unit #(.DATA_WIDTH(DW)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // idle length: mostly none or short, now and then long; none in a calm stretch
  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 45) return 0;
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // operand mix: full range, small, edge values, powers of two, halfword
  function automatic logic signed [DW-1:0] pick_operand();
    logic signed [DW-1:0] v;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: v = $urandom;
      4, 5: v = $urandom_range(0, 300);
      6: begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = 1;
          2: v = -1;
          3: v = INT_MIN;
          4: v = INT_MAX;
          default: v = INT_MIN + 1;
        endcase
      end
      7: v = (1 <<< $urandom_range(0, DW - 1)) + $signed($urandom_range(0, 2)) - 1;
      default: v = $signed(16'($urandom));
    endcase
    if (sel >= 4 && sel <= 5 && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // present one word and hold it until it is taken
  task automatic send_word(logic [FUNC_W-1:0] func, logic signed [DW-1:0] a,
                           logic signed [DW-1:0] b);
    int unsigned gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func  <= func;
    req_if.a     <= a;
    req_if.b     <= b;
    do @(posedge clk_i); while (!req_if.ready);
    if ($urandom_range(0, 59) == 0) src_calm = !src_calm;
  endtask

  task automatic send_directed();
    send_word(FUNC_MUL, '0, INT_MIN);
    send_word(FUNC_MUL, 1, -1);
    send_word(FUNC_MUL, -1, -1);
    send_word(FUNC_MUL, INT_MAX, INT_MAX);
    send_word(FUNC_MUL, INT_MIN, INT_MIN);
    send_word(FUNC_MUL, INT_MIN, -1);
    send_word(FUNC_MUL, 32'sh0001_0000, 32'sh0001_0000);
    send_word(FUNC_DIV, 7, 2);
    send_word(FUNC_DIV, -7, 2);
    send_word(FUNC_DIV, 7, -2);
    send_word(FUNC_DIV, -7, -2);
    send_word(FUNC_DIV, INT_MIN, -1);
    send_word(FUNC_DIV, INT_MIN, 1);
    send_word(FUNC_DIV, INT_MAX, INT_MIN);
    send_word(FUNC_DIV, INT_MIN, INT_MIN);
    send_word(FUNC_DIV, 5, '0);
    send_word(FUNC_REM, -7, 2);
    send_word(FUNC_REM, 7, -2);
    send_word(FUNC_REM, INT_MIN, -1);
    send_word(FUNC_REM, INT_MIN, INT_MAX);
    send_word(FUNC_REM, INT_MAX, INT_MIN);
    send_word(FUNC_REM, -5, '0);
    send_word(FUNC_UNUSED, INT_MAX, -1);
  endtask

  task automatic send_random(int unsigned count);
    logic [FUNC_W-1:0] func;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    int unsigned roll;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 33) func = FUNC_MUL;
      else if (roll < 66) func = FUNC_DIV;
      else if (roll < 98) func = FUNC_REM;
      else func = FUNC_UNUSED;
      a = pick_operand();
      b = ($urandom_range(0, 29) == 0) ? '0 : pick_operand();
      send_word(func, a, b);
    end
  endtask

  // result side backpressure
  initial begin
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = pick_gap(sink_calm);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
    end
  end

  // note accepted words on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) sb.note_request(req_if.func, req_if.a, req_if.b);
      if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.result);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // reset, stimulus, drain, verdict
  initial begin
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.func  <= FUNC_MUL;
    req_if.a     <= '0;
    req_if.b     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_directed();
    send_random(RANDOM_WORDS);
    req_if.valid <= 1'b0;
    // let the monitor note the last accepted word first
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (UNIT_LATENCY + 6) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: signed_mul_div_mod_unit.f
rtl/smdm_pkg.sv
rtl/smdm_req_if.sv
rtl/smdm_rsp_if.sv
rtl/smdm_ctrl.sv
rtl/smdm_dp.sv
rtl/signed_mul_div_mod_unit.sv
tb/sv/testbench.sv
